// ----- sv/aescbc_pkg.sv -----
// aescbc_pkg: shared types, constants and byte-level functions for the aes cbc core
// used by the round unit and the top level; no dependencies
package aescbc_pkg;

	typedef enum logic [1:0] {
		ST_EXPAND,
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic dec;
		logic first;
		logic last;
	} rnd_ctl_t;

	localparam logic [2:0] REG_KEY0  = 3'd0;
	localparam logic [2:0] REG_KEY1  = 3'd1;
	localparam logic [2:0] REG_KEY2  = 3'd2;
	localparam logic [2:0] REG_KEY3  = 3'd3;
	localparam logic [2:0] REG_IV_HI = 3'd4;
	localparam logic [2:0] REG_IV_LO = 3'd5;
	localparam logic [2:0] REG_KLEN  = 3'd6;
	localparam logic [2:0] REG_MODE  = 3'd7;

	localparam logic [1:0] MODE_ECB_ENC = 2'd0;
	localparam logic [1:0] MODE_ECB_DEC = 2'd1;
	localparam logic [1:0] MODE_CBC_ENC = 2'd2;
	localparam logic [1:0] MODE_CBC_DEC = 2'd3;

	localparam logic [1:0] KLEN_128 = 2'd0;
	localparam logic [1:0] KLEN_192 = 2'd1;

	localparam logic [0:255][7:0] SBOX = 2048'h637c777bf26b6fc53001672bfed7ab76ca82c97dfa5947f0add4a2af9ca472c0b7fd9326363ff7cc34a5e5f171d8311504c723c31896059a071280e2eb27b27509832c1a1b6e5aa0523bd6b329e32f8453d100ed20fcb15b6acbbe394a4c58cfd0efaafb434d338545f9027f503c9fa851a3408f929d38f5bcb6da2110fff3d2cd0c13ec5f974417c4a77e3d645d197360814fdc222a908846eeb814de5e0bdbe0323a0a4906245cc2d3ac629195e479e7c8376d8dd54ea96c56f4ea657aae08ba78252e1ca6b4c6e8dd741f4bbd8b8a703eb5664803f60e613557b986c11d9ee1f8981169d98e949b1e87e9ce5528df8ca1890dbfe6426841992d0fb054bb16;

	localparam logic [0:255][7:0] ISBOX = 2048'h52096ad53036a538bf40a39e81f3d7fb7ce339829b2fff87348e4344c4dee9cb547b9432a6c2233dee4c950b42fac34e082ea16628d924b2765ba2496d8bd12572f8f66486689816d4a45ccc5d65b6926c704850fdedb9da5e154657a78d9d8490d8ab008cbcd30af7e45805b8b34506d02c1e8fca3f0f02c1afbd0301138a6b3a9111414f67dcea97f2cfcef0b4e67396ac7422e7ad3585e2f937e81c75df6e47f11a711d29c5896fb7620eaa18be1bfc563e4bc6d279209adbc0fe78cd5af41fdda8338807c731b11210592780ec5f60517fa919b54a0d2de57a9f93c99cefa0e03b4dae2af5b0c8ebbb3c83539961172b047eba77d626e169146355210c7d;

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		t = '0;
		for (int i = 0; i < 16; i++) begin
			t[127 - 8 * i -: 8] = inv ? ISBOX[s[127 - 8 * i -: 8]] : SBOX[s[127 - 8 * i -: 8]];
		end
		return t;
	endfunction

	function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (inv) begin
					t[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = s[127 - 8 * (r + 4 * c) -: 8];
				end else begin
					t[127 - 8 * (r + 4 * c) -: 8] = s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8];
				end
			end
		end
		return t;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] m9 [4];
		logic [7:0] mb [4];
		logic [7:0] md [4];
		logic [7:0] me [4];
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				a[r]  = s[127 - 8 * (4 * c + r) -: 8];
				x2[r] = xt(a[r]);
				x4[r] = xt(x2[r]);
				x8[r] = xt(x4[r]);
				m9[r] = x8[r] ^ a[r];
				mb[r] = x8[r] ^ x2[r] ^ a[r];
				md[r] = x8[r] ^ x4[r] ^ a[r];
				me[r] = x8[r] ^ x4[r] ^ x2[r];
			end
			if (inv) begin
				t[127 - 32 * c -: 32] = {me[0] ^ mb[1] ^ md[2] ^ m9[3],
					m9[0] ^ me[1] ^ mb[2] ^ md[3],
					md[0] ^ m9[1] ^ me[2] ^ mb[3],
					mb[0] ^ md[1] ^ m9[2] ^ me[3]};
			end else begin
				t[127 - 32 * c -: 32] = {x2[0] ^ x2[1] ^ a[1] ^ a[2] ^ a[3],
					a[0] ^ x2[1] ^ x2[2] ^ a[2] ^ a[3],
					a[0] ^ a[1] ^ x2[2] ^ x2[3] ^ a[3],
					x2[0] ^ a[0] ^ a[1] ^ a[2] ^ x2[3]};
			end
		end
		return t;
	endfunction

endpackage

// ----- sv/aescbc_if.sv -----
// aescbc_if: request channels of the aes cbc core (input block and result block)
// no dependencies
interface aescbc_blk_if;
	logic        valid;
	logic        ready;
	logic [63:0] block_high;
	logic [63:0] block_low;
	logic        first_block;

	modport source(output valid, block_high, block_low, first_block, input ready);
	modport sink(input valid, block_high, block_low, first_block, output ready);
endinterface

interface aescbc_res_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_high;
	logic [63:0] result_low;

	modport source(output valid, result_high, result_low, input ready);
	modport sink(input valid, result_high, result_low, output ready);
endinterface

// ----- sv/aescbc_round.sv -----
// aescbc_round: shared aes round unit, one encrypt or decrypt round per use
// depends on aescbc_pkg
module aescbc_round (
	input  logic [127:0]       st,
	input  logic [127:0]       rk,
	input  aescbc_pkg::rnd_ctl_t ctl,
	output logic [127:0]       nxt
);
	import aescbc_pkg::*;

	logic [127:0] enc_v;
	logic [127:0] dec_v;

	always_comb begin
		enc_v = shift_rows(sub_bytes(st, 1'b0), 1'b0);
		if (!ctl.last) begin
			enc_v = mix_columns(enc_v, 1'b0);
		end
		enc_v = enc_v ^ rk;
		dec_v = sub_bytes(shift_rows(st, 1'b1), 1'b1) ^ rk;
		if (!ctl.last) begin
			dec_v = mix_columns(dec_v, 1'b1);
		end
		if (ctl.first) begin
			nxt = st ^ rk;
		end else if (ctl.dec) begin
			nxt = dec_v;
		end else begin
			nxt = enc_v;
		end
	end
endmodule

// ----- sv/aes_cbc_block_cipher_core.sv -----
// AES-128/192/256 core with ECB and CBC modes. After reset and after every write of a key
// word or the key length, the round keys are expanded one word per cycle and no block is
// accepted meanwhile. A block is then processed one round per cycle through a single shared
// round unit, with the round key for the next step registered from a 15-row key memory. The
// last step holds while the output register is still full and not taken; the result waits there.
module aes_cbc_block_cipher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [63:0] cfg_wdata,
	aescbc_blk_if.sink  blk,
	aescbc_res_if.source res
);
	import aescbc_pkg::*;

	state_t       state_q, state_d;
	logic [63:0]  key_q [4];
	logic [127:0] iv_q;
	logic [1:0]   klen_q;
	logic [1:0]   mode_q;
	logic [127:0] chain_q;
	logic [127:0] xv_q;
	logic         cbcdec_q;
	logic         cbcenc_q;
	logic         dec_q;
	logic [127:0] st_q;
	logic [3:0]   step_q;
	logic [5:0]   exp_i_q;
	logic [2:0]   exp_m_q;
	logic [7:0]   rcon_q;
	logic [31:0]  win_q [8];
	logic [127:0] rk_mem [15];
	logic [127:0] rk_q;
	logic [127:0] out_q;
	logic         out_v_q;

	logic [3:0]   nk, nr;
	logic [5:0]   total;
	logic [31:0]  exp_w, exp_t, key_w;
	logic [63:0]  key_sel;
	logic [3:0]   rd_row, nstep;
	logic         key_wr, accept, last, finish;
	logic [127:0] chain_eff, nxt;
	rnd_ctl_t     ctl;

	assign nk    = (klen_q == KLEN_128) ? 4'd4 : (klen_q == KLEN_192) ? 4'd6 : 4'd8;
	assign nr    = nk + 4'd6;
	assign total = {nk, 2'b00} + 6'd28;

	assign key_wr = cfg_we && (cfg_idx == REG_KEY0 || cfg_idx == REG_KEY1
		|| cfg_idx == REG_KEY2 || cfg_idx == REG_KEY3 || cfg_idx == REG_KLEN);
	assign accept = blk.valid && blk.ready;
	assign last   = step_q == nr;
	assign finish = (state_q == ST_RUN) && last && (!out_v_q || res.ready);
	assign chain_eff = blk.first_block ? iv_q : chain_q;

	// key schedule word
	always_comb begin
		key_sel = key_q[exp_i_q[2:1]];
		key_w   = exp_i_q[0] ? key_sel[31:0] : key_sel[63:32];
		exp_t   = win_q[0];
		if (exp_m_q == 3'd0) begin
			exp_t = sub_word({win_q[0][23:0], win_q[0][31:24]}) ^ {rcon_q, 24'h0};
		end else if (nk == 4'd8 && exp_m_q == 3'd4) begin
			exp_t = sub_word(win_q[0]);
		end
		exp_w = ({2'b00, exp_i_q} < {2'b00, nk, 2'b00} >> 2) ? key_w
			: (win_q[nk[2:0] - 3'd1] ^ exp_t);
	end

	// round key row for the next step
	always_comb begin
		nstep = (state_q == ST_RUN && !last) ? step_q + 4'd1 : (state_q == ST_RUN ? nr : 4'd0);
		if (state_q == ST_RUN) begin
			rd_row = dec_q ? nr - nstep : nstep;
		end else begin
			rd_row = mode_q[0] ? nr : 4'd0;
		end
	end

	assign ctl.dec   = dec_q;
	assign ctl.first = step_q == 4'd0;
	assign ctl.last  = last;

	aescbc_round u_round (
		.st  (st_q),
		.rk  (rk_q),
		.ctl (ctl),
		.nxt (nxt)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_EXPAND: if (exp_i_q == total - 6'd1) state_d = ST_IDLE;
			ST_IDLE:   if (accept) state_d = ST_RUN;
			ST_RUN:    if (finish) state_d = ST_IDLE;
			default:   state_d = ST_EXPAND;
		endcase
		if (key_wr) begin
			state_d = ST_EXPAND;
		end
	end

	assign blk.ready       = state_q == ST_IDLE;
	assign res.valid       = out_v_q;
	assign res.result_high = out_q[127:64];
	assign res.result_low  = out_q[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EXPAND;
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			iv_q     <= '0;
			klen_q   <= '0;
			mode_q   <= '0;
			chain_q  <= '0;
			out_v_q  <= 1'b0;
			exp_i_q  <= '0;
			exp_m_q  <= '0;
			rcon_q   <= 8'h01;
			step_q   <= '0;
			dec_q    <= 1'b0;
			cbcdec_q <= 1'b0;
			cbcenc_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_idx)
					REG_KEY0:  key_q[0] <= cfg_wdata;
					REG_KEY1:  key_q[1] <= cfg_wdata;
					REG_KEY2:  key_q[2] <= cfg_wdata;
					REG_KEY3:  key_q[3] <= cfg_wdata;
					REG_IV_HI: iv_q[127:64] <= cfg_wdata;
					REG_IV_LO: iv_q[63:0] <= cfg_wdata;
					REG_KLEN:  klen_q <= cfg_wdata[1:0];
					REG_MODE:  mode_q <= cfg_wdata[1:0];
					default:   ;
				endcase
			end
			if (key_wr) begin
				exp_i_q <= '0;
				exp_m_q <= '0;
				rcon_q  <= 8'h01;
			end else if (state_q == ST_EXPAND) begin
				exp_i_q <= exp_i_q + 6'd1;
				exp_m_q <= ({1'b0, exp_m_q} == nk - 4'd1) ? 3'd0 : exp_m_q + 3'd1;
				if (exp_m_q == 3'd0 && exp_i_q >= {2'b00, nk}) begin
					rcon_q <= xt(rcon_q);
				end
			end
			if (accept) begin
				step_q   <= '0;
				dec_q    <= mode_q[0];
				cbcdec_q <= mode_q == MODE_CBC_DEC;
				cbcenc_q <= mode_q == MODE_CBC_ENC;
				chain_q  <= (mode_q == MODE_CBC_DEC) ? {blk.block_high, blk.block_low}
					: chain_eff;
			end else if (state_q == ST_RUN && !last) begin
				step_q <= step_q + 4'd1;
			end
			if (finish) begin
				out_v_q <= 1'b1;
				if (cbcenc_q) begin
					chain_q <= nxt;
				end
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// datapath and key memory
	always_ff @(posedge clk) begin
		rk_q <= rk_mem[rd_row];
		if (state_q == ST_EXPAND && !key_wr) begin
			rk_mem[exp_i_q[5:2]][{~exp_i_q[1:0], 5'b00000} +: 32] <= exp_w;
			win_q[0] <= exp_w;
			for (int i = 1; i < 8; i++) win_q[i] <= win_q[i - 1];
		end
		if (accept) begin
			st_q <= {blk.block_high, blk.block_low}
				^ ((mode_q == MODE_CBC_ENC) ? chain_eff : 128'h0);
			xv_q <= chain_eff;
		end else if (state_q == ST_RUN && !last) begin
			st_q <= nxt;
		end
		if (finish) begin
			out_q <= nxt ^ (cbcdec_q ? xv_q : 128'h0);
		end
	end

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !blk.ready)
		else $error("block accepted while busy");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> step_q <= nr)
		else $error("round step past last round");

	a_expand_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXPAND |-> exp_i_q < total)
		else $error("key schedule index out of range");

	a_key_restart: assert property (@(posedge clk) disable iff (!arst_n)
		key_wr |=> state_q == ST_EXPAND && exp_i_q == 6'd0)
		else $error("key write did not restart expansion");

	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> out_v_q && state_q != ST_RUN)
		else $error("finished block not presented");
endmodule
